// ===== hdl/rgd_pkg.sv =====
// rgd_pkg: shared types, constants and the sigmoid table for the gradient step core
// no dependencies
`default_nettype none
package rgd_pkg;

    localparam int FEATURES = 32;
    localparam int FIDX_W = 5;
    localparam int SIG_SIZE = 256;
    localparam int SIG_IDX_W = 8;
    localparam int SIG_SPAN_LOG2 = 3;

    // exp step between table entries in Q32
    localparam logic [63:0] SIG_STEP = (64'd8 << 32) / 64'(SIG_SIZE);

    // config register indexes
    localparam logic [2:0] CFG_LOSS_MODE = 3'd0;
    localparam logic [2:0] CFG_STEP_SIZE = 3'd1;
    localparam logic [2:0] CFG_REG_WEIGHT = 3'd2;
    localparam logic [2:0] CFG_MOMENTUM = 3'd3;
    localparam logic [2:0] CFG_BATCH_SCALE = 3'd4;

    // opcodes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_ADD_UPDATE = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_SCORE = 2'd3;

    // loss modes
    localparam logic [1:0] MODE_QUAD = 2'd0;
    localparam logic [1:0] MODE_LOGISTIC = 2'd1;
    localparam logic [1:0] MODE_MOMENTUM = 2'd2;
    localparam logic [1:0] MODE_NESTEROV = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INNER,
        ST_TERM,
        ST_ACCUM,
        ST_UPD,
        ST_EMIT,
        ST_SCORE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic write_entry;
        logic calc_term;
        logic accum;
        logic upd_start;
        logic upd_step;
        logic idx_inc;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_idx;
        logic upd_done;
    } stat_t;

    // round half up of a 72-bit product by >>16
    function automatic logic signed [55:0] rnd16(input logic signed [71:0] p);
        logic signed [71:0] x;
        begin
            x = p + 72'sd32768;
            rnd16 = 56'(x >>> 16);
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
        if (v > 56'sh7FFFFFFFFFFF)
            sat48 = 48'sh7FFFFFFFFFFF;
        else if (v < -56'sh800000000000)
            sat48 = 48'sh800000000000;
        else
            sat48 = v[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        if (v > 56'sh7FFFFFFF)
            sat32 = 32'sh7FFFFFFF;
        else if (v < -56'sh80000000)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    // restoring shift and subtract division for the table build
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        begin
            rem = '0;
            quo = '0;
            for (int b = 63; b >= 0; b--)
            begin
                rem = {rem[63:0], num[b]};
                if (rem >= {1'b0, den})
                begin
                    rem = rem - {1'b0, den};
                    quo[b] = 1'b1;
                end
            end
            udiv64 = quo;
        end
    endfunction

    typedef logic [16:0] sig_tab_t [SIG_SIZE];

    // sigmoid table entry k = 1/(1+exp(-k*8/SIZE)) in Q0.16, integer Q32 exp
    function automatic sig_tab_t build_sig();
        sig_tab_t t;
        logic [63:0] term, base, e, den, r;
        begin
            term = 64'd1 << 32;
            base = term;
            e = 64'd1 << 32;
            for (int n = 1; n <= 24; n++)
            begin
                term = udiv64((term * SIG_STEP) >> 32, 64'(n));
                if (n[0])
                    base = base - term;
                else
                    base = base + term;
            end
            for (int k = 0; k < SIG_SIZE; k++)
            begin
                den = (64'd1 << 32) + e;
                r = udiv64((64'd1 << 48) + (den >> 1), den);
                t[k] = r[16:0];
                e = (e * base + (64'd1 << 31)) >> 32;
            end
            build_sig = t;
        end
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig();

endpackage
`default_nettype wire

// ===== hdl/rgd_ctrl.sv =====
// rgd_ctrl: sequencing state machine for the gradient step core
// depends on rgd_pkg
`default_nettype none
module rgd_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic [1:0] in_opcode,
    input  wire logic out_busy,
    input  wire logic out_take,
    input  wire rgd_pkg::stat_t stat,
    output rgd_pkg::cmd_t cmd,
    output logic in_ready,
    output logic emit_valid,
    output logic emit_score
);
    import rgd_pkg::*;

    state_t state_reg, state_next;
    logic upd_reg, upd_next;
    logic score_reg, score_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            upd_reg <= 1'b0;
            score_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            upd_reg <= upd_next;
            score_reg <= score_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        upd_next = upd_reg;
        score_next = score_reg;
        cmd = '0;
        in_ready = 1'b0;
        emit_valid = 1'b0;
        emit_score = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    if (in_opcode == OP_WRITE)
                        cmd.write_entry = 1'b1;
                    else
                    begin
                        cmd.load = 1'b1;
                        upd_next = (in_opcode == OP_ADD_UPDATE);
                        score_next = (in_opcode == OP_SCORE);
                        state_next = ST_INNER;
                    end
                end
            end
            ST_INNER:
            begin
                // adder tree result registered in datapath
                state_next = score_reg ? ST_SCORE : ST_TERM;
            end
            ST_TERM:
            begin
                cmd.calc_term = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (upd_reg)
                begin
                    cmd.upd_start = 1'b1;
                    state_next = ST_UPD;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_UPD:
            begin
                cmd.upd_step = 1'b1;
                if (stat.upd_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_busy || out_take)
                begin
                    emit_valid = 1'b1;
                    if (stat.last_idx)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        cmd.upd_start = 1'b1;
                        state_next = ST_UPD;
                    end
                end
            end
            ST_SCORE:
            begin
                if (!out_busy || out_take)
                begin
                    emit_valid = 1'b1;
                    emit_score = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/rgd_dp.sv =====
// rgd_dp: weight, momentum and gradient storage with inner product, term and update units
// depends on rgd_pkg
`default_nettype none
module rgd_dp (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire rgd_pkg::cmd_t cmd,
    output rgd_pkg::stat_t stat,
    input  wire logic [1:0] loss_mode,
    input  wire logic [15:0] step_size,
    input  wire logic [15:0] reg_weight,
    input  wire logic [15:0] momentum_coeff,
    input  wire logic [16:0] batch_scale,
    input  wire logic [31:0] feature_bits,
    input  wire logic label,
    input  wire logic [4:0] entry_index,
    input  wire logic signed [31:0] weight_in,
    input  wire logic signed [31:0] momentum_in,
    output logic [4:0] emit_index,
    output logic signed [31:0] emit_weight,
    output logic signed [39:0] ip_out
);
    import rgd_pkg::*;

    logic signed [31:0] w_reg [FEATURES];
    logic signed [31:0] v_reg [FEATURES];
    logic signed [47:0] g_reg [FEATURES];
    logic [31:0] bits_reg;
    logic pos_reg;
    logic signed [39:0] ip_reg;
    logic signed [47:0] t_reg;
    logic [FIDX_W-1:0] idx_reg;
    logic [1:0] ph_reg;
    logic signed [55:0] a_reg, b_reg;
    logic signed [31:0] wnew_reg;

    // signed lane values and pairwise adder tree over features
    logic signed [39:0] lane [FEATURES];
    logic signed [39:0] ip_sum;
    always_comb
    begin
        for (int i = 0; i < FEATURES; i++)
            lane[i] = bits_reg[i] ? (pos_reg ? 40'(w_reg[i]) : -40'(w_reg[i])) : '0;
        for (int s = 1; s < FEATURES; s = s * 2)
            for (int i = 0; i < FEATURES; i = i + 2 * s)
                lane[i] = lane[i] + lane[i + s];
        ip_sum = lane[0];
    end

    // logistic f from table
    logic [39:0] mag;
    logic [39:0] tidx;
    logic [16:0] sval;
    logic signed [17:0] f;
    logic [16:0] bs;
    always_comb
    begin
        mag = ip_reg[39] ? 40'(-ip_reg) : 40'(ip_reg);
        tidx = mag >> (16 + SIG_SPAN_LOG2 - SIG_IDX_W);
        sval = (tidx < 40'(SIG_SIZE)) ? SIG_TAB[tidx[SIG_IDX_W-1:0]] : 17'd65536;
        f = ip_reg[39] ? 18'(sval) : 18'sd65536 - 18'(sval);
        bs = (batch_scale > 17'd65536) ? 17'd65536 : batch_scale;
    end

    logic signed [71:0] tprod;
    always_comb
    begin
        if (loss_mode == MODE_QUAD)
            tprod = 72'((ip_reg - 40'sd65536) * 2) * $signed({1'b0, bs});
        else
            tprod = -(72'(f) * $signed({1'b0, bs}));
    end

    // per-feature update arithmetic, computed in phases on one multiplier pair
    logic signed [31:0] w_i, v_i;
    logic signed [47:0] g_i;
    logic signed [71:0] m1, m2;
    logic signed [47:0] tot;
    logic signed [31:0] u;
    always_comb
    begin
        w_i = w_reg[idx_reg];
        v_i = v_reg[idx_reg];
        g_i = g_reg[idx_reg];
        m1 = '0;
        m2 = '0;
        tot = sat48(a_reg + 56'(g_i));
        u = sat32(56'(w_i) - a_reg);
        case (loss_mode)
            MODE_QUAD, MODE_LOGISTIC:
            begin
                if (ph_reg == 2'd0)
                    m1 = $signed({1'b0, reg_weight}) * 72'(w_i);
                else
                    m1 = $signed({1'b0, step_size}) * 72'(tot);
            end
            MODE_MOMENTUM:
            begin
                m1 = $signed({1'b0, momentum_coeff}) * 72'(v_i);
                m2 = $signed({1'b0, step_size}) * 72'(g_i);
            end
            default:
            begin
                if (ph_reg == 2'd0)
                    m1 = $signed({1'b0, step_size}) * 72'(g_i);
                else
                begin
                    m1 = $signed({1'b0, 17'd65536 - {1'b0, momentum_coeff}}) * 72'(u);
                    m2 = $signed({1'b0, momentum_coeff}) * 72'(v_i);
                end
            end
        endcase
    end

    assign stat.last_idx = (idx_reg == FIDX_W'(FEATURES - 1));
    assign stat.upd_done = (ph_reg == 2'd2);
    assign emit_index = idx_reg;
    assign emit_weight = wnew_reg;
    assign ip_out = ip_reg;

    // sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FEATURES; i++)
            begin
                w_reg[i] <= '0;
                v_reg[i] <= '0;
                g_reg[i] <= '0;
            end
            idx_reg <= '0;
            ph_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            wnew_reg <= '0;
        end
        else
        begin
            if (cmd.write_entry)
            begin
                w_reg[entry_index] <= weight_in;
                v_reg[entry_index] <= momentum_in;
            end
            if (cmd.load)
                idx_reg <= '0;
            if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.accum)
            begin
                for (int i = 0; i < FEATURES; i++)
                    if (bits_reg[i])
                        g_reg[i] <= sat48(56'(g_reg[i]) + (pos_reg ? 56'(t_reg) : -56'(t_reg)));
            end
            if (cmd.upd_start)
                ph_reg <= 2'd0;
            else if (cmd.upd_step && ph_reg != 2'd2)
            begin
                ph_reg <= ph_reg + 1'b1;
                case (loss_mode)
                    MODE_QUAD, MODE_LOGISTIC:
                    begin
                        if (ph_reg == 2'd0)
                            a_reg <= rnd16(m1);
                        else
                        begin
                            wnew_reg <= sat32(56'(w_i) - rnd16(m1));
                            w_reg[idx_reg] <= sat32(56'(w_i) - rnd16(m1));
                            g_reg[idx_reg] <= '0;
                        end
                    end
                    MODE_MOMENTUM:
                    begin
                        if (ph_reg == 2'd0)
                        begin
                            a_reg <= rnd16(m1);
                            b_reg <= rnd16(m2);
                        end
                        else
                        begin
                            v_reg[idx_reg] <= sat32(a_reg + b_reg);
                            wnew_reg <= sat32(56'(w_i) - 56'(sat32(a_reg + b_reg)));
                            w_reg[idx_reg] <= sat32(56'(w_i) - 56'(sat32(a_reg + b_reg)));
                            g_reg[idx_reg] <= '0;
                        end
                    end
                    default:
                    begin
                        if (ph_reg == 2'd0)
                            a_reg <= rnd16(m1);
                        else
                        begin
                            wnew_reg <= sat32(rnd16(m1 + m2));
                            w_reg[idx_reg] <= sat32(rnd16(m1 + m2));
                            v_reg[idx_reg] <= u;
                            g_reg[idx_reg] <= '0;
                        end
                    end
                endcase
            end
        end
    end

    // sample payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bits_reg <= feature_bits;
            pos_reg <= label;
        end
        ip_reg <= ip_sum;
        if (cmd.calc_term)
            t_reg <= (loss_mode == MODE_QUAD || loss_mode == MODE_LOGISTIC)
                ? 48'(rnd16(tprod)) : 48'(f) * -48'sd1;
    end

endmodule
`default_nettype wire

// ===== hdl/regression_gradient_descent_step_core.sv =====
// regression_gradient_descent_step_core: top level with config registers and output register
// depends on rgd_pkg, rgd_ctrl, rgd_dp
`default_nettype none
// Gradient step trainer for a 32-feature binary linear model in Q16.16.
// An add request runs the inner product tree, the loss term (from the
// sigmoid table unless in quadratic mode) and the gradient accumulate.
// An add-and-update request then runs the shared update multipliers and
// an emit per feature, emitting all 32 weights in index order; each emit
// waits while the result register is full and not taken. A score request
// yields one result; a weight write is done in idle. The result register
// holds one result so the core works on the next feature while it waits.
module regression_gradient_descent_step_core (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic s_tready,
    // opcode[1:0], feature_bits[33:2], label[34], entry_index[39:35],
    // weight_in[71:40], momentum_in[103:72]
    input  wire logic [103:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // weight_index[4:0], weight_out[36:5], score[76:37], positive[77]
    output logic [79:0] m_tdata,
    // result_kind
    output logic m_tuser,
    output logic m_tlast,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [16:0] cfg_wdata
);
    import rgd_pkg::*;

    logic [1:0] loss_mode_reg;
    logic [15:0] step_reg, lambda_reg, eta_reg;
    logic [16:0] bscale_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loss_mode_reg <= MODE_LOGISTIC;
            step_reg <= 16'd6554;
            lambda_reg <= '0;
            eta_reg <= '0;
            bscale_reg <= 17'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOSS_MODE: loss_mode_reg <= cfg_wdata[1:0];
                CFG_STEP_SIZE: step_reg <= cfg_wdata[15:0];
                CFG_REG_WEIGHT: lambda_reg <= cfg_wdata[15:0];
                CFG_MOMENTUM: eta_reg <= cfg_wdata[15:0];
                CFG_BATCH_SCALE: bscale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cmd_t cmd;
    stat_t stat;
    logic emit_valid, emit_score, in_fire;
    logic [4:0] e_idx;
    logic signed [31:0] e_w;
    logic signed [39:0] ip;

    assign in_fire = s_tvalid & s_tready;

    rgd_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_opcode(s_tdata[1:0]),
        .out_busy(m_tvalid), .out_take(m_tready), .stat(stat), .cmd(cmd),
        .in_ready(s_tready), .emit_valid(emit_valid), .emit_score(emit_score)
    );

    rgd_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .loss_mode(loss_mode_reg), .step_size(step_reg), .reg_weight(lambda_reg),
        .momentum_coeff(eta_reg), .batch_scale(bscale_reg),
        .feature_bits(s_tdata[33:2]), .label(s_tdata[34]),
        .entry_index(s_tdata[39:35]), .weight_in(s_tdata[71:40]),
        .momentum_in(s_tdata[103:72]),
        .emit_index(e_idx), .emit_weight(e_w), .ip_out(ip)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid <= 1'b0;
        else if (emit_valid)
            m_tvalid <= 1'b1;
        else if (m_tready)
            m_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            if (emit_score)
            begin
                m_tdata <= {2'b00, (ip > 40'sd0), ip, 32'd0, 5'd0};
                m_tuser <= 1'b1;
                m_tlast <= 1'b1;
            end
            else
            begin
                m_tdata <= {2'b00, 1'b0, 40'd0, e_w, e_idx};
                m_tuser <= 1'b0;
                m_tlast <= stat.last_idx;
            end
        end
    end

endmodule
`default_nettype wire
